// ----- hw/rtl/ddft_pkg.sv -----
// Shared types, constants and the sine table builder for the direct DFT block.
// No dependencies; all other source files but ddft_ram use this package.
package ddft_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int BIN_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam int COUNT_W    = 7;
    localparam int STEP_W     = 25;
    localparam int ANGLE_W    = 24;
    localparam int TAB_FRAC   = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEP   = 2'd2;

    localparam logic [COUNT_W-1:0] RST_POINT_COUNT = 7'd64;
    localparam logic [STEP_W-1:0]  RST_TURN_STEP   = 25'd262144;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_MAC,
        S_DRAIN,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_ready;
        logic bin_start;
        logic mac_issue;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic frame_done;
        logic last_n;
        logic pipe_busy;
        logic div_done;
        logic out_taken;
        logic last_k;
    } t_status;

    // Quarter-wave sine in unsigned Q0.15 for step r of 2^(ab-2) per quarter turn.
    function automatic logic [14:0] f_quarter_sine(input int unsigned r, input int unsigned ab);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        begin
            x  = (64'(r) * 64'd1686629713) >> (ab - 2);
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            s  = (s + 64'd16384) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            return s[14:0];
        end
    endfunction

endpackage

// ----- hw/rtl/ddft_if.sv -----
// Handshake interfaces for the sample, bin and configuration channels.
// Depends on ddft_pkg for the field widths.
interface ddft_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ddft_pkg::SAMPLE_W-1:0]  sample_real;
    logic signed [ddft_pkg::SAMPLE_W-1:0]  sample_imag;
    modport source (output valid, output sample_real, output sample_imag, input ready);
    modport sink (input valid, input sample_real, input sample_imag, output ready);
endinterface

interface ddft_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ddft_pkg::BIN_W-1:0]  bin_real;
    logic signed [ddft_pkg::BIN_W-1:0]  bin_imag;
    logic                               bin_last;
    modport source (output valid, output bin_real, output bin_imag, output bin_last,
                    input ready);
    modport sink (input valid, input bin_real, input bin_imag, input bin_last,
                  output ready);
endinterface

interface ddft_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ddft_pkg::CFG_IDX_W-1:0]      index;
    logic [ddft_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/ddft_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ddft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- hw/rtl/ddft_ctrl.sv -----
// Sequencer for loading, per-bin accumulation, division and bin output.
// Depends on ddft_pkg for the state, command and status types.
module ddft_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ddft_pkg::t_status i_st,
    output ddft_pkg::t_cmd    o_cmd
);
    import ddft_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_st.frame_done) n_state = S_START;
            end
            S_START: n_state = S_MAC;
            S_MAC: begin
                if (i_st.last_n) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_st.pipe_busy) n_state = S_DIV;
            end
            S_DIV: begin
                if (i_st.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_st.out_taken) n_state = i_st.last_k ? S_LOAD : S_START;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_LOAD:  o_cmd.load_ready = 1'b1;
            S_START: o_cmd.bin_start  = 1'b1;
            S_MAC:   o_cmd.mac_issue  = 1'b1;
            S_DRAIN: o_cmd.div_start  = !i_st.pipe_busy;
            S_DIV:   o_cmd.out_load   = i_st.div_done;
            S_OUT:   o_cmd            = '0;
            default: o_cmd            = '0;
        endcase
    end

    a_div_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !i_st.pipe_busy)
        else $error("Division started with products still in flight.");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_st.out_taken && i_st.last_k) |=> (r_state == S_LOAD))
        else $error("Controller did not return to loading after the last bin.");
endmodule

// ----- hw/rtl/ddft_datapath.sv -----
// Sample store, phase and table lookup, complex multiply-accumulate, divider, output.
// Depends on ddft_pkg, the ddft interfaces and ddft_ram.
module ddft_datapath #(
    parameter int MAX_POINTS  = 64,
    parameter int ANGLE_BITS  = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ddft_pkg::t_cmd    i_cmd,
    output ddft_pkg::t_status o_st,
    ddft_in_if.sink           i_sample,
    ddft_out_if.source        o_bin,
    ddft_cfg_if.sink          i_cfg
);
    import ddft_pkg::*;

    localparam int IW    = $clog2(MAX_POINTS);
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = 2 * SB + IW + 2;
    localparam int QW    = AW - TAB_FRAC;
    localparam int RW    = IW + 2;
    localparam int CW    = $clog2(QW + 1);
    localparam int QSIZE = 2 ** (ANGLE_BITS - 2);
    localparam int PW    = SB + 16;

    // Configuration registers.
    logic               r_dir;
    logic [COUNT_W-1:0] r_pcount;
    logic [STEP_W-1:0]  r_tstep;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= 1'b0;
            r_pcount <= RST_POINT_COUNT;
            r_tstep  <= RST_TURN_STEP;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DIRECTION:   r_dir    <= i_cfg.data[0];
                CFG_POINT_COUNT: r_pcount <= i_cfg.data[COUNT_W-1:0];
                CFG_TURN_STEP:   r_tstep  <= i_cfg.data[STEP_W-1:0];
                default:         r_dir    <= r_dir;
            endcase
        end
    end

    logic [NW-1:0] w_n;
    always_comb begin
        if (r_pcount == '0) begin
            w_n = NW'(1);
        end else if (32'(r_pcount) > MAX_POINTS) begin
            w_n = NW'(MAX_POINTS);
        end else begin
            w_n = NW'(r_pcount);
        end
    end

    // Loading.
    logic          w_accept;
    logic [NW-1:0] r_cnt;
    logic [IW-1:0] w_wr_addr;
    logic [NW-1:0] w_cnt_inc;
    logic          w_frame_done;
    logic [SB-1:0] w_sre;
    logic [SB-1:0] w_sim;

    assign i_sample.ready = i_cmd.load_ready;
    assign w_accept       = i_sample.valid && i_cmd.load_ready;
    assign w_wr_addr      = (r_cnt >= w_n) ? '0 : r_cnt[IW-1:0];
    assign w_cnt_inc      = NW'(w_wr_addr) + NW'(1);
    assign w_frame_done   = w_accept && (w_cnt_inc == w_n);

    generate
        if (SB <= SAMPLE_W) begin : g_narrow
            assign w_sre = i_sample.sample_real[SB-1:0];
            assign w_sim = i_sample.sample_imag[SB-1:0];
        end else begin : g_wide
            assign w_sre = SB'(unsigned'(i_sample.sample_real));
            assign w_sim = SB'(unsigned'(i_sample.sample_imag));
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_accept) begin
            r_cnt <= w_frame_done ? '0 : w_cnt_inc;
        end
    end

    // Bin and sample counters.
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_n;
    logic [IW-1:0] r_p;
    logic [IW:0]   w_p_sum;
    logic [IW-1:0] w_p_next;

    assign w_p_sum  = {1'b0, r_p} + {1'b0, r_k};
    assign w_p_next = (w_p_sum >= (IW + 1)'(w_n)) ? IW'(w_p_sum - (IW + 1)'(w_n))
                                                   : w_p_sum[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_n <= '0;
            r_p <= '0;
        end else begin
            if (w_frame_done) begin
                r_k <= '0;
            end else if (o_bin.valid && o_bin.ready) begin
                r_k <= r_k + IW'(1);
            end
            if (i_cmd.bin_start) begin
                r_n <= '0;
                r_p <= '0;
            end else if (i_cmd.mac_issue) begin
                r_n <= r_n + IW'(1);
                r_p <= w_p_next;
            end
        end
    end

    logic [2*SB-1:0] w_rd_data;

    ddft_ram #(
        .WIDTH (2 * SB),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (w_wr_addr),
        .i_wr_data ({w_sre, w_sim}),
        .i_rd_addr (r_n),
        .o_rd_data (w_rd_data)
    );

    // Stage 1: turn fraction of the phase.
    logic                 r_v1;
    logic [ANGLE_W-1:0]   r_ang;
    logic [IW+STEP_W-1:0] w_ang_prod;

    assign w_ang_prod = (IW + STEP_W)'(r_p) * (IW + STEP_W)'(r_tstep);

    always_ff @(posedge i_clk) begin
        r_ang <= w_ang_prod[ANGLE_W-1:0];
    end

    // Stage 2: table lookup and sample alignment.
    logic [14:0]           w_qtab [QSIZE+1];
    logic [ANGLE_W:0]      w_ang_rnd;
    logic [ANGLE_BITS-1:0] w_idx_s;
    logic [ANGLE_BITS-1:0] w_idx_c;
    logic [ANGLE_BITS-2:0] w_rs;
    logic [ANGLE_BITS-2:0] w_rc;
    logic signed [15:0]    w_sin;
    logic signed [15:0]    w_cos;
    logic                  r_v2;
    logic signed [15:0]    r_sin;
    logic signed [15:0]    r_cos;
    logic signed [SB-1:0]  r_xr;
    logic signed [SB-1:0]  r_xi;

    genvar gi;
    generate
        for (gi = 0; gi <= QSIZE; gi++) begin : g_qtab
            assign w_qtab[gi] = f_quarter_sine(gi, ANGLE_BITS);
        end
    endgenerate

    assign w_ang_rnd = {1'b0, r_ang} + (ANGLE_W + 1)'(1 << (ANGLE_W - 1 - ANGLE_BITS));
    assign w_idx_s   = w_ang_rnd[ANGLE_W-1:ANGLE_W-ANGLE_BITS];
    assign w_idx_c   = w_idx_s + ANGLE_BITS'(QSIZE);

    always_comb begin
        w_rs = {1'b0, w_idx_s[ANGLE_BITS-3:0]};
        w_rc = {1'b0, w_idx_c[ANGLE_BITS-3:0]};
        if (w_idx_s[ANGLE_BITS-2]) w_rs = (ANGLE_BITS - 1)'(QSIZE) - w_rs;
        if (w_idx_c[ANGLE_BITS-2]) w_rc = (ANGLE_BITS - 1)'(QSIZE) - w_rc;
        w_sin = signed'({1'b0, w_qtab[w_rs]});
        w_cos = signed'({1'b0, w_qtab[w_rc]});
        if (w_idx_s[ANGLE_BITS-1]) w_sin = -w_sin;
        if (w_idx_c[ANGLE_BITS-1]) w_cos = -w_cos;
    end

    always_ff @(posedge i_clk) begin
        r_sin <= r_dir ? w_sin : -w_sin;
        r_cos <= w_cos;
        r_xr  <= signed'(w_rd_data[2*SB-1:SB]);
        r_xi  <= r_dir ? signed'(w_rd_data[SB-1:0]) : '0;
    end

    // Stage 3: four partial products.
    logic                 r_v3;
    logic signed [PW-1:0] r_m_rc;
    logic signed [PW-1:0] r_m_is;
    logic signed [PW-1:0] r_m_ic;
    logic signed [PW-1:0] r_m_rs;

    always_ff @(posedge i_clk) begin
        r_m_rc <= r_xr * r_cos;
        r_m_is <= r_xi * r_sin;
        r_m_ic <= r_xi * r_cos;
        r_m_rs <= r_xr * r_sin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage 4: accumulation.
    logic signed [AW-1:0] r_acc_re;
    logic signed [AW-1:0] r_acc_im;

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_start) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v3) begin
            r_acc_re <= r_acc_re + AW'(r_m_rc) - AW'(r_m_is);
            r_acc_im <= r_acc_im + AW'(r_m_ic) + AW'(r_m_rs);
        end
    end

    // Bit-serial restoring divider, both parts at once.
    logic [AW-1:0] w_mag_re;
    logic [AW-1:0] w_mag_im;
    logic [RW-1:0] w_div;
    logic [CW-1:0] r_div_cnt;
    logic [QW-1:0] r_dq_re;
    logic [QW-1:0] r_dq_im;
    logic [RW-1:0] r_rem_re;
    logic [RW-1:0] r_rem_im;
    logic [RW-1:0] w_sh_re;
    logic [RW-1:0] w_sh_im;
    logic          w_ge_re;
    logic          w_ge_im;
    logic          r_neg_re;
    logic          r_neg_im;

    assign w_mag_re = r_acc_re[AW-1] ? AW'(-r_acc_re) : AW'(r_acc_re);
    assign w_mag_im = r_acc_im[AW-1] ? AW'(-r_acc_im) : AW'(r_acc_im);
    assign w_div    = r_dir ? RW'(1) : RW'(w_n);
    assign w_sh_re  = {r_rem_re[RW-2:0], r_dq_re[QW-1]};
    assign w_sh_im  = {r_rem_im[RW-2:0], r_dq_im[QW-1]};
    assign w_ge_re  = w_sh_re >= w_div;
    assign w_ge_im  = w_sh_im >= w_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= CW'(QW);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq_re  <= w_mag_re[AW-1:TAB_FRAC];
            r_dq_im  <= w_mag_im[AW-1:TAB_FRAC];
            r_rem_re <= '0;
            r_rem_im <= '0;
            r_neg_re <= r_acc_re[AW-1];
            r_neg_im <= r_acc_im[AW-1];
        end else if (r_div_cnt != '0) begin
            r_dq_re  <= {r_dq_re[QW-2:0], w_ge_re};
            r_dq_im  <= {r_dq_im[QW-2:0], w_ge_im};
            r_rem_re <= w_ge_re ? w_sh_re - w_div : w_sh_re;
            r_rem_im <= w_ge_im ? w_sh_im - w_div : w_sh_im;
        end
    end

    // Sign, saturation and output register.
    logic signed [QW:0]    w_sv_re;
    logic signed [QW:0]    w_sv_im;
    logic signed [63:0]    w_ext_re;
    logic signed [63:0]    w_ext_im;
    logic signed [BIN_W-1:0] w_sat_re;
    logic signed [BIN_W-1:0] w_sat_im;
    logic                  r_out_valid;
    logic signed [BIN_W-1:0] r_bin_re;
    logic signed [BIN_W-1:0] r_bin_im;
    logic                  r_bin_last;
    logic                  w_last_k;

    assign w_sv_re  = r_neg_re ? -signed'({1'b0, r_dq_re}) : signed'({1'b0, r_dq_re});
    assign w_sv_im  = r_neg_im ? -signed'({1'b0, r_dq_im}) : signed'({1'b0, r_dq_im});
    assign w_ext_re = 64'(w_sv_re);
    assign w_ext_im = 64'(w_sv_im);

    always_comb begin
        w_sat_re = BIN_W'(w_ext_re);
        w_sat_im = BIN_W'(w_ext_im);
        if (w_ext_re > 64'sh7FFF_FFFF) w_sat_re = 32'sh7FFF_FFFF;
        if (w_ext_re < -64'sh8000_0000) w_sat_re = 32'sh8000_0000;
        if (w_ext_im > 64'sh7FFF_FFFF) w_sat_im = 32'sh7FFF_FFFF;
        if (w_ext_im < -64'sh8000_0000) w_sat_im = 32'sh8000_0000;
    end

    assign w_last_k = (NW'(r_k) == w_n - NW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_bin.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_bin_re   <= w_sat_re;
            r_bin_im   <= w_sat_im;
            r_bin_last <= w_last_k;
        end
    end

    assign o_bin.valid    = r_out_valid;
    assign o_bin.bin_real = r_bin_re;
    assign o_bin.bin_imag = r_bin_im;
    assign o_bin.bin_last = r_bin_last;

    assign o_st.frame_done = w_frame_done;
    assign o_st.last_n     = (NW'(r_n) == w_n - NW'(1));
    assign o_st.pipe_busy  = r_v1 || r_v2 || r_v3;
    assign o_st.div_done   = (r_div_cnt == '0);
    assign o_st.out_taken  = r_out_valid && o_bin.ready;
    assign o_st.last_k     = w_last_k;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_POINTS)
        else $error("Load count ran past the store depth.");

    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !r_out_valid)
        else $error("Sample taken while a bin was still pending.");
endmodule

// ----- hw/rtl/direct_dft_forward_inverse.sv -----
// Top of the direct O(N^2) DFT: forward on real parts with 1/N scaling, inverse unscaled.
// Depends on ddft_pkg, the ddft interfaces, ddft_ctrl and ddft_datapath.
//
//  channel    dir  payload                          accepted when
//  i_sample   in   sample_real, sample_imag         valid && ready
//  o_bin      out  bin_real, bin_imag, bin_last     valid && ready
//  i_cfg      in   index, data                      valid && ready (ready always high)
//
// Samples are taken one per cycle while loading; the N-th sample starts the transform.
// Each bin passes through a start state, N issues through the one multiply-accumulate
// pipeline, a drain until that pipeline is empty, a 25-step bit-serial divide at
// default widths, and an output state that lasts until the bin is taken.
// No sample is accepted from the start of a transform until its last bin is taken.
// Synchronous active-low reset clears control and configuration; the store is not cleared.
// A stalled bin holds the output and the sequencer until it is taken.
module direct_dft_forward_inverse #(
    parameter int MAX_POINTS  = 64,
    parameter int ANGLE_BITS  = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ddft_in_if.sink     i_sample,
    ddft_out_if.source  o_bin,
    ddft_cfg_if.sink    i_cfg
);
    import ddft_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;

    ddft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    ddft_datapath #(
        .MAX_POINTS  (MAX_POINTS),
        .ANGLE_BITS  (ANGLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_st     (w_st),
        .i_sample (i_sample),
        .o_bin    (o_bin),
        .i_cfg    (i_cfg)
    );
endmodule

// ----- tb/tb_direct_dft_forward_inverse.sv -----
`timescale 1ns / 100ps
// Testbench for the direct DFT block: loads frames of samples under several settings
// and checks every bin against a bit-exact predictor. Depends on every design file.

class bin_scoreboard;
    int unsigned direction;
    int unsigned point_count;
    int unsigned turn_step;
    int signed   frame_re[64];
    int signed   frame_im[64];
    int unsigned loaded;
    logic signed [31:0] want_re[$];
    logic signed [31:0] want_im[$];
    logic               want_last[$];
    int unsigned        errors;

    function new();
        direction   = 0;
        point_count = 64;
        turn_step   = 262144;
        loaded      = 0;
        errors      = 0;
    endfunction

    function void set_reg(int unsigned idx, int unsigned val);
        if (idx == ddft_pkg::CFG_DIRECTION) direction = val & 1;
        else if (idx == ddft_pkg::CFG_POINT_COUNT) point_count = val & 'h7f;
        else if (idx == ddft_pkg::CFG_TURN_STEP) turn_step = val & 'h1ffffff;
    endfunction

    function int unsigned frame_len();
        if (point_count == 0) return 1;
        if (point_count > 64) return 64;
        return point_count;
    endfunction

    function longint quarter_wave(longint unsigned r);
        longint unsigned x, x2, t, s;
        int unsigned     dv[5];
        dv = '{110, 72, 42, 20, 6};
        x  = (r * 64'd1686629713) >> 8;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int i = 0; i < 5; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / dv[i];
        s = (x * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 32767) s = 32767;
        return longint'(s);
    endfunction

    function longint sine_at(int unsigned idx);
        int unsigned q, r;
        idx = idx & 1023;
        q = idx >> 8;
        r = idx & 255;
        case (q)
            0: return quarter_wave(r);
            1: return quarter_wave(256 - r);
            2: return -quarter_wave(r);
            default: return -quarter_wave(256 - r);
        endcase
    endfunction

    function logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
        int unsigned n_pts;
        longint      ar, ai, xr, xi, c, s, d;
        longint unsigned a;
        int unsigned idx;
        n_pts = frame_len();
        if (loaded >= n_pts) loaded = 0;
        frame_re[loaded] = re;
        frame_im[loaded] = im;
        loaded++;
        if (loaded < n_pts) return;
        loaded = 0;
        for (int k = 0; k < n_pts; k++) begin
            ar = 0;
            ai = 0;
            for (int n = 0; n < n_pts; n++) begin
                a   = (longint'((k * n) % n_pts) * longint'(turn_step)) & 64'hffffff;
                idx = int'((a + 64'd8192) >> 14);
                c   = sine_at(idx + 256);
                s   = sine_at(idx);
                xr  = frame_re[n];
                xi  = frame_im[n];
                if (direction == 0) begin
                    ar += xr * c;
                    ai -= xr * s;
                end else begin
                    ar += xr * c - xi * s;
                    ai += xi * c + xr * s;
                end
            end
            d = (direction == 0) ? longint'(n_pts) * 32768 : 32768;
            ar = ar / d;
            ai = ai / d;
            want_re.push_back(clip32(ar));
            want_im.push_back(clip32(ai));
            want_last.push_back(k == n_pts - 1);
        end
    endfunction

    function void check_bin(logic signed [31:0] re, logic signed [31:0] im, logic last);
        if (want_re.size() == 0) begin
            $display("%0t: unexpected bin re=%0d im=%0d last=%0b", $time, re, im, last);
            errors++;
            return;
        end
        if (re !== want_re[0] || im !== want_im[0] || last !== want_last[0]) begin
            $display({"%0t: bin mismatch expected re=%0d im=%0d last=%0b",
                      " actual re=%0d im=%0d last=%0b"},
                     $time, want_re[0], want_im[0], want_last[0], re, im, last);
            errors++;
        end
        void'(want_re.pop_front());
        void'(want_im.pop_front());
        void'(want_last.pop_front());
    endfunction

    function int unsigned pending();
        return want_re.size();
    endfunction
endclass

module tb_direct_dft_forward_inverse;
    import ddft_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   stall_mode;

    ddft_in_if  smp_ch ();
    ddft_out_if bin_ch ();
    ddft_cfg_if cfg_ch ();

    bin_scoreboard sb = new();

    direct_dft_forward_inverse dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_ch.sink),
        .o_bin    (bin_ch.source),
        .i_cfg    (cfg_ch.sink)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        smp_ch.valid = 1'b0;
        smp_ch.sample_real = '0;
        smp_ch.sample_imag = '0;
        bin_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && bin_ch.valid && bin_ch.ready) begin
            sb.check_bin(bin_ch.bin_real, bin_ch.bin_imag, bin_ch.bin_last);
        end
        if (stall_mode) begin
            bin_ch.ready <= ($urandom_range(0, 3) != 0);
        end else begin
            bin_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val, bit keep);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_reg(idx, val);
        if (!keep) cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im, bit keep);
        smp_ch.valid       <= 1'b1;
        smp_ch.sample_real <= re;
        smp_ch.sample_imag <= im;
        do @(posedge i_clk); while (!smp_ch.ready);
        sb.note_sample(re, im);
        if (!keep) smp_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_frames(int unsigned count);
        int unsigned burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst--;
            send_sample(rand_sample(), rand_sample(), (burst != 0) && (i != count - 1));
        end
    endtask

    task automatic set_mode(int unsigned dir, int unsigned pts, int unsigned step);
        write_reg(CFG_DIRECTION, dir, 1'b1);
        write_reg(CFG_POINT_COUNT, pts, 1'b1);
        write_reg(CFG_TURN_STEP, step, 1'b0);
    endtask

    initial begin
        stall_mode = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_mode(0, 4, 4194304);
        send_sample(16'sh7fff, 16'sh7fff, 1'b1);
        send_sample(16'sh8000, 16'sh8000, 1'b1);
        send_sample(16'sh0000, 16'shffff, 1'b1);
        send_sample(16'sh0001, 16'sh0001, 1'b0);
        drain();
        set_mode(1, 4, 4194304);
        send_sample(16'sh7fff, 16'sh8000, 1'b1);
        send_sample(16'sh8000, 16'sh7fff, 1'b1);
        send_sample(16'sh7fff, 16'sh7fff, 1'b1);
        send_sample(16'sh8000, 16'sh8000, 1'b0);
        drain();
        set_mode(1, 0, 16777216);
        send_sample(16'sh8000, 16'sh7fff, 1'b1);
        send_sample(16'sh1234, 16'shedcb, 1'b0);
        drain();
        set_mode(0, 100, 0);
        random_frames(64);
        drain();
        set_mode(0, 8, 2097152);
        random_frames(5);
        drain();
        write_reg(CFG_POINT_COUNT, 3, 1'b1);
        write_reg(CFG_UNUSED, 0, 1'b0);
        send_sample(16'sh7fff, 16'sh0000, 1'b0);
        drain();

        stall_mode = 1'b1;
        set_mode(1, 8, 2097152);
        random_frames(24);
        drain();
        set_mode(0, 5, 3355443);
        random_frames(24);
        drain();
        stall_mode = 1'b0;
        set_mode(1, 16, 1048576);
        random_frames(48);
        drain();
        stall_mode = 1'b1;
        set_mode(0, 64, 33554431);
        random_frames(64);
        drain();
        set_mode(1, 2, 8388608);
        random_frames(16);
        drain();

        if (sb.errors == 0) begin
            $display("tb_direct_dft_forward_inverse: done, clean");
        end else begin
            $display("tb_direct_dft_forward_inverse: done, errors");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("tb_direct_dft_forward_inverse: done, errors");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/ddft_pkg.sv
hw/rtl/ddft_if.sv
hw/rtl/ddft_ram.sv
hw/rtl/ddft_ctrl.sv
hw/rtl/ddft_datapath.sv
hw/rtl/direct_dft_forward_inverse.sv
tb/tb_direct_dft_forward_inverse.sv
